/* rtl/ppft_pkg.sv */
// Shared definitions for the planar pose frame transform block.
// Holds width defaults, register index and operation codes, and the trig constants.
// No dependencies.
package ppft_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int ANGLE_WIDTH_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_X       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_Y       = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_HEADING = 2'd2;

    // Operation codes
    localparam logic OP_TO_WORLD = 1'b0;
    localparam logic OP_TO_LOCAL = 1'b1;

    // pi/2 and 1.0 in Q30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Horner series term indexes: sine runs 14 down to 2, cosine 13 down to 1
    localparam logic [3:0] K_SINE_FIRST = 4'd14;
    localparam logic [3:0] K_COS_FIRST  = 4'd13;
    localparam logic [3:0] K_LAST       = 4'd2;

    localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;

    // Divisor k*(k+1) of one Horner step
    function automatic logic [7:0] horner_divisor(input logic [3:0] k);
        logic [7:0] k_ext;
        k_ext = {4'b0000, k};
        return 8'(k_ext * (k_ext + 8'd1));
    endfunction

    // Reciprocal floor(2^32 / (k*(k+1))) of one Horner step's divisor
    function automatic logic [31:0] horner_recip(input logic [3:0] k);
        logic [31:0] m;
        unique case (k)
            4'd1:    m = 32'(TWO_POW_32 / 64'd2);
            4'd2:    m = 32'(TWO_POW_32 / 64'd6);
            4'd3:    m = 32'(TWO_POW_32 / 64'd12);
            4'd4:    m = 32'(TWO_POW_32 / 64'd20);
            4'd5:    m = 32'(TWO_POW_32 / 64'd30);
            4'd6:    m = 32'(TWO_POW_32 / 64'd42);
            4'd7:    m = 32'(TWO_POW_32 / 64'd56);
            4'd8:    m = 32'(TWO_POW_32 / 64'd72);
            4'd9:    m = 32'(TWO_POW_32 / 64'd90);
            4'd10:   m = 32'(TWO_POW_32 / 64'd110);
            4'd11:   m = 32'(TWO_POW_32 / 64'd132);
            4'd12:   m = 32'(TWO_POW_32 / 64'd156);
            4'd13:   m = 32'(TWO_POW_32 / 64'd182);
            4'd14:   m = 32'(TWO_POW_32 / 64'd210);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/ppft_trig.sv */
// Sine and cosine sequencer for the frame heading of the pose transform.
// Shares one 32x32 multiplier across all its steps; each Horner division is a reciprocal
// multiply with a one-step correction. Depends on ppft_pkg.
module ppft_trig #(
    parameter int ANGLE_WIDTH    = ppft_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = ppft_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [ANGLE_WIDTH-1:0]           heading,
    output logic                             busy,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val
);

    localparam int CSW       = TRIG_FRAC_BITS + 2;
    localparam int RND_SHIFT = 30 - TRIG_FRAC_BITS;
    localparam int PAD       = 32 - ANGLE_WIDTH;

    localparam logic [31:0] TRIG_HALF = 32'(1) << (RND_SHIFT - 1);
    localparam logic [63:0] Q30_HALF  = 64'h0000_0000_2000_0000;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_X_LO   = 4'd1;
    localparam logic [3:0] ST_X_HI   = 4'd2;
    localparam logic [3:0] ST_X_SUM  = 4'd3;
    localparam logic [3:0] ST_SQ_MUL = 4'd4;
    localparam logic [3:0] ST_SQ_RND = 4'd5;
    localparam logic [3:0] ST_H_MUL  = 4'd6;
    localparam logic [3:0] ST_H_RCP  = 4'd7;
    localparam logic [3:0] ST_H_CHK  = 4'd8;
    localparam logic [3:0] ST_H_FIX  = 4'd9;
    localparam logic [3:0] ST_H_UPD  = 4'd10;
    localparam logic [3:0] ST_S_MUL  = 4'd11;
    localparam logic [3:0] ST_S_RND  = 4'd12;
    localparam logic [3:0] ST_FINISH = 4'd13;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            quad_reg, quad_next;
    logic [29:0]           r_reg, r_next;
    logic [45:0]           acc_reg, acc_next;
    logic [63:0]           mul_reg, mul_next;
    logic [30:0]           x_reg, x_next;
    logic [31:0]           x2_reg, x2_next;
    logic [30:0]           t_reg, t_next;
    logic [3:0]            k_reg, k_next;
    logic                  sine_phase_reg, sine_phase_next;
    logic [30:0]           sq_reg, sq_next;
    logic [31:0]           quo_reg, quo_next;
    logic [31:0]           dvd_reg, dvd_next;
    logic signed [CSW-1:0] cos_reg, cos_next;
    logic signed [CSW-1:0] sin_reg, sin_next;

    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    x_sum;
    logic [63:0]    x2_sum;
    logic [7:0]     divisor;
    logic [31:0]    recip;
    logic [31:0]    rem_est;
    logic           rem_ge;
    logic [31:0]    s_sum;
    logic [31:0]    c_sum;
    logic [CSW-1:0] s_pos;
    logic [CSW-1:0] c_pos;
    logic [CSW-1:0] s_neg;
    logic [CSW-1:0] c_neg;

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_X_LO:
            begin
                mul_a = {17'b0, r_reg[14:0]};
                mul_b = {1'b0, ppft_pkg::HALF_PI_Q30};
            end
            ST_X_HI:
            begin
                mul_a = {17'b0, r_reg[29:15]};
                mul_b = {1'b0, ppft_pkg::HALF_PI_Q30};
            end
            ST_SQ_MUL:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            ST_H_MUL:
            begin
                mul_a = x2_reg;
                mul_b = {1'b0, t_reg};
            end
            ST_H_RCP:
            begin
                // Dividend times reciprocal: quotient estimate in the top word
                mul_a = mul_reg[61:30];
                mul_b = recip;
            end
            ST_H_CHK:
            begin
                // Estimate times divisor, to check the remainder
                mul_a = mul_reg[63:32];
                mul_b = {24'b0, divisor};
            end
            ST_S_MUL:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, t_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_next = {32'b0, mul_a} * {32'b0, mul_b};
    end

    assign x_sum   = 64'(acc_reg) + (mul_reg << 15) + Q30_HALF;
    assign x2_sum  = mul_reg + Q30_HALF;
    assign divisor = ppft_pkg::horner_divisor(k_reg);
    assign recip   = ppft_pkg::horner_recip(k_reg);
    // The estimate is never high and at most one low, so the remainder is below 2*divisor
    assign rem_est = dvd_reg - mul_reg[31:0];
    assign rem_ge  = (rem_est >= {24'b0, divisor});

    // Round Q30 results to the output fraction width
    assign s_sum = 32'(sq_reg) + TRIG_HALF;
    assign c_sum = 32'(t_reg) + TRIG_HALF;
    assign s_pos = {1'b0, s_sum[RND_SHIFT+TRIG_FRAC_BITS:RND_SHIFT]};
    assign c_pos = {1'b0, c_sum[RND_SHIFT+TRIG_FRAC_BITS:RND_SHIFT]};
    assign s_neg = CSW'(0) - s_pos;
    assign c_neg = CSW'(0) - c_pos;

    always_comb
    begin
        state_next      = state_reg;
        quad_next       = quad_reg;
        r_next          = r_reg;
        acc_next        = acc_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        t_next          = t_reg;
        k_next          = k_reg;
        sine_phase_next = sine_phase_reg;
        sq_next         = sq_reg;
        quo_next        = quo_reg;
        dvd_next        = dvd_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        if (load)
        begin
            // Restart on every heading write; scale the angle to a 32-bit turn
            state_next = ST_X_LO;
            quad_next  = heading[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
            r_next     = {heading[ANGLE_WIDTH-3:0], {PAD{1'b0}}};
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    state_next = ST_IDLE;
                end
                ST_X_LO:
                begin
                    state_next = ST_X_HI;
                end
                ST_X_HI:
                begin
                    acc_next   = mul_reg[45:0];
                    state_next = ST_X_SUM;
                end
                ST_X_SUM:
                begin
                    x_next     = x_sum[60:30];
                    state_next = ST_SQ_MUL;
                end
                ST_SQ_MUL:
                begin
                    state_next = ST_SQ_RND;
                end
                ST_SQ_RND:
                begin
                    x2_next         = x2_sum[61:30];
                    t_next          = ppft_pkg::Q30_ONE;
                    k_next          = ppft_pkg::K_SINE_FIRST;
                    sine_phase_next = 1'b1;
                    state_next      = ST_H_MUL;
                end
                ST_H_MUL:
                begin
                    state_next = ST_H_RCP;
                end
                ST_H_RCP:
                begin
                    dvd_next   = mul_reg[61:30];
                    state_next = ST_H_CHK;
                end
                ST_H_CHK:
                begin
                    quo_next   = mul_reg[63:32];
                    state_next = ST_H_FIX;
                end
                ST_H_FIX:
                begin
                    // Bump the estimate when a whole divisor is left over
                    if (rem_ge)
                    begin
                        quo_next = quo_reg + 32'd1;
                    end
                    state_next = ST_H_UPD;
                end
                ST_H_UPD:
                begin
                    if (quo_reg >= {1'b0, ppft_pkg::Q30_ONE})
                    begin
                        t_next = '0;
                    end
                    else
                    begin
                        t_next = 31'({1'b0, ppft_pkg::Q30_ONE} - quo_reg);
                    end
                    if (k_reg <= ppft_pkg::K_LAST)
                    begin
                        state_next = sine_phase_reg ? ST_S_MUL : ST_FINISH;
                    end
                    else
                    begin
                        k_next     = k_reg - 4'd2;
                        state_next = ST_H_MUL;
                    end
                end
                ST_S_MUL:
                begin
                    state_next = ST_S_RND;
                end
                ST_S_RND:
                begin
                    sq_next         = mul_reg[60:30];
                    t_next          = ppft_pkg::Q30_ONE;
                    k_next          = ppft_pkg::K_COS_FIRST;
                    sine_phase_next = 1'b0;
                    state_next      = ST_H_MUL;
                end
                ST_FINISH:
                begin
                    unique case (quad_reg)
                        QUAD_0:
                        begin
                            sin_next = s_pos;
                            cos_next = c_pos;
                        end
                        QUAD_1:
                        begin
                            sin_next = c_pos;
                            cos_next = s_neg;
                        end
                        QUAD_2:
                        begin
                            sin_next = s_neg;
                            cos_next = c_neg;
                        end
                        QUAD_3:
                        begin
                            sin_next = c_neg;
                            cos_next = s_pos;
                        end
                        default:
                        begin
                            sin_next = sin_reg;
                            cos_next = cos_reg;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cos_reg   <= CSW'(1) << TRIG_FRAC_BITS;
            sin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg       <= quad_next;
        r_reg          <= r_next;
        acc_reg        <= acc_next;
        mul_reg        <= mul_next;
        x_reg          <= x_next;
        x2_reg         <= x2_next;
        t_reg          <= t_next;
        k_reg          <= k_next;
        sine_phase_reg <= sine_phase_next;
        sq_reg         <= sq_next;
        quo_reg        <= quo_next;
        dvd_reg        <= dvd_next;
    end

    assign busy    = (state_reg != ST_IDLE);
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

/* rtl/planar_pose_frame_transform_top.sv */
// Top level of the planar pose frame transform (SE(2) point/pose mapping).
// Holds the frame registers and the five-stage transform pipeline.
// Depends on ppft_pkg and ppft_trig.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low; op, point_x, point_y and point_heading are sampled at that edge.
//   op 0 maps local to world, op 1 maps world to local.
//   Result channel: done pulses for one cycle with out_x, out_y, out_heading and
//   saturated valid; the receiver cannot stall, so every result is taken.
//   Pipeline: a transaction passes through the stage A, B, C, D and E
//   registers, and its result is taken from the stage E register.
//   Throughput: one transaction per cycle, back to back, whenever busy is low.
//   Configuration: cfg_we writes cfg_data to register cfg_index at the edge
//   (0 frame_x, 1 frame_y, 2 frame_heading; index 3 is dropped). Write only
//   while no transaction is in flight.
//   A frame_heading write starts the sine/cosine sequencer: one shared 32x32
//   multiplier runs 14 Horner steps (multiply, reciprocal, check, fix, update),
//   dividing by a reciprocal multiply and a one-step correction, and busy is
//   high until it ends. Another heading write while busy restarts the sequence.
//   Reset: frame position and heading clear to zero, cosine to one, sine to
//   zero, busy low, and the pipeline drops anything in flight.
module planar_pose_frame_transform_top #(
    parameter int COORD_WIDTH    = ppft_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH    = ppft_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = ppft_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     op,
    input  logic signed [COORD_WIDTH-1:0]            point_x,
    input  logic signed [COORD_WIDTH-1:0]            point_y,
    input  logic signed [ANGLE_WIDTH-1:0]            point_heading,
    output logic                                     done,
    output logic signed [COORD_WIDTH-1:0]            out_x,
    output logic signed [COORD_WIDTH-1:0]            out_y,
    output logic signed [ANGLE_WIDTH-1:0]            out_heading,
    output logic                                     saturated,
    input  logic                                     cfg_we,
    input  logic [ppft_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_data
);

    // Datapath widths: difference, trig value, product, rotated sum, rounded
    // rotation and final sum before saturation
    localparam int AXW = COORD_WIDTH + 1;
    localparam int CSW = TRIG_FRAC_BITS + 2;
    localparam int PW  = AXW + CSW;
    localparam int SW  = PW + 1;
    localparam int RW  = SW - TRIG_FRAC_BITS;
    localparam int EW  = RW + 1;

    localparam logic [SW-1:0]          ROUND_HALF = SW'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic [COORD_WIDTH-1:0] SAT_MAX    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN    = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Frame registers
    logic signed [COORD_WIDTH-1:0] frame_x_reg;
    logic signed [COORD_WIDTH-1:0] frame_y_reg;
    logic signed [ANGLE_WIDTH-1:0] frame_heading_reg;
    logic                          heading_load;
    logic signed [CSW-1:0]         cos_val;
    logic signed [CSW-1:0]         sin_val;
    logic                          rot_bypass;

    // Stage A: input register
    logic                          a_valid_reg;
    logic                          a_op_reg;
    logic signed [COORD_WIDTH-1:0] a_x_reg;
    logic signed [COORD_WIDTH-1:0] a_y_reg;
    logic signed [ANGLE_WIDTH-1:0] a_heading_reg;

    // Stage B: frame offset removed (to-local), heading combined
    logic                          b_valid_reg;
    logic                          b_op_reg;
    logic signed [AXW-1:0]         b_x_reg, b_x_next;
    logic signed [AXW-1:0]         b_y_reg, b_y_next;
    logic signed [ANGLE_WIDTH-1:0] b_heading_reg, b_heading_next;

    // Stage C: rotation products
    logic                          c_valid_reg;
    logic                          c_op_reg;
    logic signed [AXW-1:0]         c_x_reg;
    logic signed [AXW-1:0]         c_y_reg;
    logic signed [ANGLE_WIDTH-1:0] c_heading_reg;
    logic signed [PW-1:0]          prod_xc_reg, prod_xc_next;
    logic signed [PW-1:0]          prod_ys_reg, prod_ys_next;
    logic signed [PW-1:0]          prod_yc_reg, prod_yc_next;
    logic signed [PW-1:0]          prod_xs_reg, prod_xs_next;

    // Stage D: rotated and rounded coordinates
    logic                          d_valid_reg;
    logic                          d_op_reg;
    logic signed [RW-1:0]          d_x_reg, d_x_next;
    logic signed [RW-1:0]          d_y_reg, d_y_next;
    logic signed [ANGLE_WIDTH-1:0] d_heading_reg;
    logic [SW-1:0]                 rot_sum_x;
    logic [SW-1:0]                 rot_sum_y;

    // Stage E: result register
    logic                          done_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [COORD_WIDTH-1:0] out_y_reg, out_y_next;
    logic signed [ANGLE_WIDTH-1:0] out_heading_reg;
    logic                          saturated_reg, saturated_next;
    logic signed [EW-1:0]          e_x;
    logic signed [EW-1:0]          e_y;
    logic                          fit_x;
    logic                          fit_y;

    logic accept;

    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Configuration writes; a heading write also kicks the trig sequencer
    // ------------------------------------------------------------------
    assign heading_load = cfg_we && (cfg_index == ppft_pkg::REG_FRAME_HEADING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_x_reg       <= '0;
            frame_y_reg       <= '0;
            frame_heading_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppft_pkg::REG_FRAME_X:       frame_x_reg       <= cfg_data[COORD_WIDTH-1:0];
                ppft_pkg::REG_FRAME_Y:       frame_y_reg       <= cfg_data[COORD_WIDTH-1:0];
                ppft_pkg::REG_FRAME_HEADING: frame_heading_reg <= cfg_data[ANGLE_WIDTH-1:0];
                default:
                begin
                    // Unused index: drop the write
                    frame_x_reg <= frame_x_reg;
                end
            endcase
        end
    end

    ppft_trig #(
        .ANGLE_WIDTH    (ANGLE_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (heading_load),
        .heading (cfg_data[ANGLE_WIDTH-1:0]),
        .busy    (busy),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // A zero heading skips the rotation for an exact identity
    assign rot_bypass = (frame_heading_reg == '0);

    // ------------------------------------------------------------------
    // Stage B: subtract frame position for to-local, combine headings
    // ------------------------------------------------------------------
    always_comb
    begin
        if (a_op_reg == ppft_pkg::OP_TO_LOCAL)
        begin
            b_x_next       = AXW'(a_x_reg) - AXW'(frame_x_reg);
            b_y_next       = AXW'(a_y_reg) - AXW'(frame_y_reg);
            b_heading_next = a_heading_reg - frame_heading_reg;
        end
        else
        begin
            b_x_next       = AXW'(a_x_reg);
            b_y_next       = AXW'(a_y_reg);
            b_heading_next = a_heading_reg + frame_heading_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: four products against cosine and sine
    // ------------------------------------------------------------------
    assign prod_xc_next = PW'(b_x_reg) * PW'(cos_val);
    assign prod_ys_next = PW'(b_y_reg) * PW'(sin_val);
    assign prod_yc_next = PW'(b_y_reg) * PW'(cos_val);
    assign prod_xs_next = PW'(b_x_reg) * PW'(sin_val);

    // ------------------------------------------------------------------
    // Stage D: combine products by direction, round half up, drop fraction
    // ------------------------------------------------------------------
    always_comb
    begin
        if (c_op_reg == ppft_pkg::OP_TO_WORLD)
        begin
            rot_sum_x = SW'(prod_xc_reg) - SW'(prod_ys_reg) + ROUND_HALF;
            rot_sum_y = SW'(prod_yc_reg) + SW'(prod_xs_reg) + ROUND_HALF;
        end
        else
        begin
            rot_sum_x = SW'(prod_xc_reg) + SW'(prod_ys_reg) + ROUND_HALF;
            rot_sum_y = SW'(prod_yc_reg) - SW'(prod_xs_reg) + ROUND_HALF;
        end
        if (rot_bypass)
        begin
            d_x_next = RW'(c_x_reg);
            d_y_next = RW'(c_y_reg);
        end
        else
        begin
            d_x_next = rot_sum_x[SW-1:TRIG_FRAC_BITS];
            d_y_next = rot_sum_y[SW-1:TRIG_FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: add frame position for to-world, then saturate
    // ------------------------------------------------------------------
    always_comb
    begin
        if (d_op_reg == ppft_pkg::OP_TO_WORLD)
        begin
            e_x = EW'(d_x_reg) + EW'(frame_x_reg);
            e_y = EW'(d_y_reg) + EW'(frame_y_reg);
        end
        else
        begin
            e_x = EW'(d_x_reg);
            e_y = EW'(d_y_reg);
        end
        // In range when every bit from the target sign bit up agrees
        fit_x = (&e_x[EW-1:COORD_WIDTH-1]) || !(|e_x[EW-1:COORD_WIDTH-1]);
        fit_y = (&e_y[EW-1:COORD_WIDTH-1]) || !(|e_y[EW-1:COORD_WIDTH-1]);
        if (fit_x)
        begin
            out_x_next = e_x[COORD_WIDTH-1:0];
        end
        else
        begin
            out_x_next = e_x[EW-1] ? SAT_MIN : SAT_MAX;
        end
        if (fit_y)
        begin
            out_y_next = e_y[COORD_WIDTH-1:0];
        end
        else
        begin
            out_y_next = e_y[EW-1] ? SAT_MIN : SAT_MAX;
        end
        saturated_next = !fit_x || !fit_y;
    end

    // ------------------------------------------------------------------
    // Pipeline valid chain: advance one stage per cycle, never stall
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            done_reg    <= d_valid_reg;
        end
    end

    // Payload follows the valid chain unconditionally
    always_ff @(posedge clk)
    begin
        a_op_reg        <= op;
        a_x_reg         <= point_x;
        a_y_reg         <= point_y;
        a_heading_reg   <= point_heading;

        b_op_reg        <= a_op_reg;
        b_x_reg         <= b_x_next;
        b_y_reg         <= b_y_next;
        b_heading_reg   <= b_heading_next;

        c_op_reg        <= b_op_reg;
        c_x_reg         <= b_x_reg;
        c_y_reg         <= b_y_reg;
        c_heading_reg   <= b_heading_reg;
        prod_xc_reg     <= prod_xc_next;
        prod_ys_reg     <= prod_ys_next;
        prod_yc_reg     <= prod_yc_next;
        prod_xs_reg     <= prod_xs_next;

        d_op_reg        <= c_op_reg;
        d_x_reg         <= d_x_next;
        d_y_reg         <= d_y_next;
        d_heading_reg   <= c_heading_reg;

        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_heading_reg <= d_heading_reg;
        saturated_reg   <= saturated_next;
    end

    assign done        = done_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_heading = out_heading_reg;
    assign saturated   = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every accepted transaction produces a result once it has passed stages A to E
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without a matching transaction");

    // A heading write holds off new transactions while trig is recomputed
    assert property (@(posedge clk) disable iff (!rst_n)
        heading_load |=> busy)
        else $error("busy not raised after heading write");

    // The saturation flag implies a coordinate sits at a bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (out_x == SAT_MAX || out_x == SAT_MIN ||
                                 out_y == SAT_MAX || out_y == SAT_MIN))
        else $error("saturated set with no clipped coordinate");

endmodule

/* tb/ppft_checker.sv */
// Checker for the planar pose frame transform: mirrors the frame registers,
// predicts each result from the accepted transaction and compares it field by field.
// Depends on ppft_pkg for the register index and operation codes.
module ppft_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 op,
    input  logic signed [31:0]                   point_x,
    input  logic signed [31:0]                   point_y,
    input  logic signed [15:0]                   point_heading,
    input  logic                                 done,
    input  logic signed [31:0]                   out_x,
    input  logic signed [31:0]                   out_y,
    input  logic signed [15:0]                   out_heading,
    input  logic                                 saturated,
    input  logic                                 cfg_we,
    input  logic [ppft_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                          cfg_data,
    output int                                   mismatch_count,
    output int                                   outstanding
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        heading;
        logic               sat;
    } pose_t;

    localparam longint unsigned ONE_Q30       = 64'd1 << 30;
    localparam longint unsigned QTR_TURN_Q30  = 64'd1686629713;
    localparam longint          COORD_MAX     = 64'sd2147483647;
    localparam longint          COORD_MIN     = -64'sd2147483648;

    logic signed [31:0] frame_x_m;
    logic signed [31:0] frame_y_m;
    logic [15:0]        frame_h_m;
    logic signed [17:0] cos_m;
    logic signed [17:0] sin_m;
    pose_t              pending_q[$];
    int                 fail_tally;

    assign mismatch_count = fail_tally;

    // One Horner pass of the series, Q30, each step clamped at zero
    function automatic longint unsigned horner_q30(input longint unsigned x2, input int k_top);
        longint unsigned t;
        longint unsigned q;
        int              k;
        t = ONE_Q30;
        for (k = k_top; k >= 1; k -= 2)
        begin
            q = ((x2 * t) >> 30) / longint'(k * (k + 1));
            t = (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
        end
        return t;
    endfunction

    function automatic void heading_trig(input logic [15:0] h,
                                         output logic signed [17:0] c,
                                         output logic signed [17:0] s);
        logic [31:0]     turn;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned sq;
        longint unsigned cq;
        longint          sv;
        longint          cv;
        turn = {h, 16'h0000};
        r    = turn[29:0];
        x    = (r * QTR_TURN_Q30 + (64'd1 << 29)) >> 30;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        sq   = (x * horner_q30(x2, 14)) >> 30;
        cq   = horner_q30(x2, 13);
        sv   = longint'((sq + (64'd1 << 13)) >> 14);
        cv   = longint'((cq + (64'd1 << 13)) >> 14);
        case (turn[31:30])
            2'd0:    begin s = 18'(sv);  c = 18'(cv);  end
            2'd1:    begin s = 18'(cv);  c = 18'(-sv); end
            2'd2:    begin s = 18'(-sv); c = 18'(-cv); end
            default: begin s = 18'(-cv); c = 18'(sv);  end
        endcase
    endfunction

    function automatic longint round_q16(input longint acc);
        return (acc + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
            return 32'sh7FFF_FFFF;
        if (v < COORD_MIN)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic pose_t map_pose(input logic op_in,
                                       input logic signed [31:0] px,
                                       input logic signed [31:0] py,
                                       input logic [15:0] ph);
        longint ax;
        longint ay;
        longint c;
        longint s;
        longint nx;
        longint ny;
        pose_t  r;
        c = cos_m;
        s = sin_m;
        if (op_in == ppft_pkg::OP_TO_WORLD)
        begin
            ax = px;
            ay = py;
        end
        else
        begin
            ax = longint'(px) - longint'(frame_x_m);
            ay = longint'(py) - longint'(frame_y_m);
        end
        if (frame_h_m == 16'h0000)
        begin
            nx = ax;
            ny = ay;
        end
        else if (op_in == ppft_pkg::OP_TO_WORLD)
        begin
            nx = round_q16(ax * c - ay * s);
            ny = round_q16(ay * c + ax * s);
        end
        else
        begin
            nx = round_q16(ax * c + ay * s);
            ny = round_q16(ay * c - ax * s);
        end
        if (op_in == ppft_pkg::OP_TO_WORLD)
        begin
            nx        = nx + longint'(frame_x_m);
            ny        = ny + longint'(frame_y_m);
            r.heading = ph + frame_h_m;
        end
        else
        begin
            r.heading = ph - frame_h_m;
        end
        r.x   = clamp_coord(nx);
        r.y   = clamp_coord(ny);
        r.sat = (longint'(r.x) != nx) || (longint'(r.y) != ny);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        if (!rst_n)
        begin
            frame_x_m = '0;
            frame_y_m = '0;
            frame_h_m = '0;
            cos_m     = 18'sd65536;
            sin_m     = '0;
            pending_q.delete();
            fail_tally  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppft_pkg::REG_FRAME_X: frame_x_m = cfg_data;
                    ppft_pkg::REG_FRAME_Y: frame_y_m = cfg_data;
                    ppft_pkg::REG_FRAME_HEADING:
                    begin
                        frame_h_m = cfg_data[15:0];
                        heading_trig(frame_h_m, cos_m, sin_m);
                    end
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_q.push_back(map_pose(op, point_x, point_y, point_heading));
            if (done)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_tally++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, out_x);
                        fail_tally++;
                    end
                    if (out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, out_y);
                        fail_tally++;
                    end
                    if (out_heading !== want.heading)
                    begin
                        $error("out_heading: expected %0d, got %0d",
                               $signed(want.heading), out_heading);
                        fail_tally++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0d, got %0d", want.sat, saturated);
                        fail_tally++;
                    end
                end
            end
            outstanding <= pending_q.size();
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for planar_pose_frame_transform_top: drives frame writes and
// transactions, runs the watchdog and prints the verdict.
// Depends on ppft_pkg, ppft_checker and the block itself.
module tb;

    localparam int COORD_W    = ppft_pkg::COORD_WIDTH_DEF;
    localparam int ANGLE_W    = ppft_pkg::ANGLE_WIDTH_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 86;

    // Index 3 is not a register: writes to it must leave the frame alone
    localparam logic [ppft_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    logic                                 clk   = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 op    = 1'b0;
    logic signed [COORD_W-1:0]            point_x = '0;
    logic signed [COORD_W-1:0]            point_y = '0;
    logic signed [ANGLE_W-1:0]            point_heading = '0;
    logic                                 cfg_we = 1'b0;
    logic [ppft_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [COORD_W-1:0]                   cfg_data = '0;
    logic                                 busy;
    logic                                 done;
    logic signed [COORD_W-1:0]            out_x;
    logic signed [COORD_W-1:0]            out_y;
    logic signed [ANGLE_W-1:0]            out_heading;
    logic                                 saturated;
    int                                   mismatch_count;
    int                                   outstanding;
    int                                   quiet_cycles = 0;

    // Current frame position, kept so that random points can land near it
    logic signed [COORD_W-1:0]            anchor_x = '0;
    logic signed [COORD_W-1:0]            anchor_y = '0;

    always #2 clk = ~clk;

    planar_pose_frame_transform_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_heading(point_heading),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_heading  (out_heading),
        .saturated    (saturated),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ppft_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_heading (point_heading),
        .done          (done),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_heading   (out_heading),
        .saturated     (saturated),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    // Watchdog: count edges where neither a transaction nor a result is taken.
    // The longest honest quiet stretch is the sine/cosine sequencer after a
    // heading write, so the limit sits well above it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("planar_pose_frame_transform_top: mismatch");
                $finish;
            end
        end
    end

    // Present one transaction and hold it until the block takes it.
    // Start stays high on return so the next transaction can follow back to back.
    task automatic drive_cmd(input logic o, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [ANGLE_W-1:0] h);
        start         <= 1'b1;
        op            <= o;
        point_x       <= x;
        point_y       <= y;
        point_heading <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait for every predicted result to come back, then let
    // the pipeline run empty before anything touches the frame registers.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One register write per edge; the caller lowers the write enable afterwards
    task automatic write_reg(input logic [ppft_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [COORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Load a whole frame. Poke the unused index on the way, and fill the
    // heading write's upper bits with noise since the block must ignore them.
    task automatic load_frame(input logic signed [COORD_W-1:0] fx,
                              input logic signed [COORD_W-1:0] fy,
                              input logic [ANGLE_W-1:0] fh);
        write_reg(ppft_pkg::REG_FRAME_X, fx);
        write_reg(ppft_pkg::REG_FRAME_Y, fy);
        write_reg(REG_UNUSED, $urandom);
        write_reg(ppft_pkg::REG_FRAME_HEADING, {16'($urandom), fh});
        cfg_we   <= 1'b0;
        anchor_x = fx;
        anchor_y = fy;
    endtask

    // Coordinate mix: bound values, full-range noise, small values around the
    // origin and small offsets from the frame position (typical local points).
    function automatic logic signed [COORD_W-1:0] pick_coord(
        input logic signed [COORD_W-1:0] anchor);
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return 32'sd0;
                    3:       return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            4, 5, 6: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            7, 8:    return anchor + ($signed($urandom_range(0, 32'h0002_0000))
                                      - 32'sh0001_0000);
            default: return $urandom;
        endcase
    endfunction

    int                        phase;
    int                        item;
    int                        burst_odds;
    logic [ANGLE_W-1:0]        phase_heading;
    logic signed [COORD_W-1:0] phase_x;
    logic signed [COORD_W-1:0] phase_y;

    initial
    begin
        // Hold reset at the start, then release it once for the whole run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset frame: identity, both operations, bound values of every field
        drive_cmd(ppft_pkg::OP_TO_WORLD, 32'sd0, 32'sd0, 16'h0000);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MAX, COORD_MAX, 16'h7FFF);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MIN, COORD_MIN, 16'h8000);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MAX, COORD_MIN, 16'h0001);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MIN, COORD_MAX, 16'hFFFF);
        settle();

        // Zero heading with the frame at the corners: no rotation, only the
        // position add/subtract, which clips and raises the flag on the first two
        load_frame(COORD_MAX, COORD_MIN, 16'h0000);
        drive_cmd(ppft_pkg::OP_TO_WORLD, 32'sd1, -32'sd1, 16'h0000);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MIN, COORD_MAX, 16'h0064);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MIN, COORD_MAX, 16'h8000);
        settle();

        // Quarter turn: exact cosine zero, sine one
        load_frame(32'sh0001_8000, -32'sh0002_0000, 16'h4000);
        drive_cmd(ppft_pkg::OP_TO_WORLD, 32'sh0001_0000, 32'sd0, 16'h0100);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, 32'sh0001_8000, -32'sh0001_0000, 16'hC000);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MAX, COORD_MAX, 16'h7FFF);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MIN, COORD_MIN, 16'h8000);
        settle();

        // Half turn with the frame at opposite corners: rotation plus offset overflow
        load_frame(COORD_MIN, COORD_MAX, 16'h8000);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MIN, COORD_MIN, 16'h0000);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MAX, COORD_MIN, 16'h7FFF);
        drive_cmd(ppft_pkg::OP_TO_WORLD, COORD_MAX, COORD_MAX, 16'h8001);
        drive_cmd(ppft_pkg::OP_TO_LOCAL, COORD_MIN, COORD_MAX, 16'h1234);
        settle();

        // Random phases: walk the heading through the quadrant edges, the smallest
        // steps and an eighth turn, then random values; move the frame between
        // origin, the corners, small and full-range positions
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       phase_heading = 16'h0000;
                1:       phase_heading = 16'h4000;
                2:       phase_heading = 16'h8000;
                3:       phase_heading = 16'h7FFF;
                4:       phase_heading = 16'hC000;
                5:       phase_heading = 16'h0001;
                6:       phase_heading = 16'hFFFF;
                7:       phase_heading = 16'h2000;
                default: phase_heading = 16'($urandom);
            endcase
            case (phase % 4)
                0:
                begin
                    phase_x = 32'sd0;
                    phase_y = 32'sd0;
                end
                1:
                begin
                    phase_x = (phase < 4) ? COORD_MAX : COORD_MIN;
                    phase_y = (phase < 4) ? COORD_MIN : COORD_MAX;
                end
                2:
                begin
                    phase_x = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                    phase_y = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                end
                default:
                begin
                    phase_x = $urandom;
                    phase_y = $urandom;
                end
            endcase
            load_frame(phase_x, phase_y, phase_heading);

            // Vary the sender's gaps per phase; keep the last phase gap-free
            case (phase % 3)
                0:       burst_odds = 0;
                1:       burst_odds = 3;
                default: burst_odds = 10;
            endcase
            if (phase == PHASES - 1)
                burst_odds = 0;

            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                drive_cmd(1'($urandom_range(0, 1)), pick_coord(anchor_x),
                          pick_coord(anchor_y), 16'($urandom));
                if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
            // Hold off the next frame until everything in flight has returned
            settle();
        end

        if (mismatch_count == 0 && outstanding == 0)
            $display("planar_pose_frame_transform_top: match");
        else
            $display("planar_pose_frame_transform_top: mismatch");
        $finish;
    end

endmodule
